### rtl/core/bdq_pkg.sv
// Package for the bounded deque with rotation.
// Holds operation and status codes and the cell control type; no dependencies.
package bdq_pkg;

    typedef enum logic [3:0] {
        KIND_CLEAR_ENABLE = 4'd0,
        KIND_PUSH_BACK    = 4'd1,
        KIND_PUSH_FRONT   = 4'd2,
        KIND_POP_FRONT    = 4'd3,
        KIND_POP_BACK     = 4'd4,
        KIND_SHIFT_RIGHT  = 4'd5,
        KIND_ROTATE_LEFT  = 4'd6,
        KIND_ROTATE_RIGHT = 4'd7,
        KIND_READ         = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_NOT_ENABLED = 3'd1,
        STATUS_EMPTY       = 3'd2,
        STATUS_FULL        = 3'd3,
        STATUS_BAD_INDEX   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD  = 3'b001,
        CELL_BACK  = 3'b010,
        CELL_FRONT = 3'b100
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
    } cell_ctrl_t;

endpackage

### rtl/core/bdq_req_if.sv
// Request channel of the bounded deque: valid, ready and operation payload.
// No dependencies.
interface bdq_req_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [3:0]            kind;
    logic [VALUE_BITS-1:0] cargo;
    logic [3:0]            index;

    modport source (output valid, output kind, output cargo, output index, input ready);
    modport sink   (input valid, input kind, input cargo, input index, output ready);
endinterface

### rtl/core/bdq_rsp_if.sv
// Response channel of the bounded deque: valid, ready and result payload.
// No dependencies.
interface bdq_rsp_if #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 5
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] value_out;
    logic [COUNT_BITS-1:0] count;
    logic                  enabled;

    modport source (output valid, output status, output value_out, output count,
                    output enabled, input ready);
    modport sink   (input valid, input status, input value_out, input count,
                    input enabled, output ready);
endinterface

### rtl/core/bdq_cell.sv
// One storage cell of the deque chain: holds one entry, shifts to either neighbor.
// Depends on bdq_pkg.
module bdq_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  bdq_pkg::cell_ctrl_t   ctrl,
    input  logic                  load,
    input  logic [VALUE_BITS-1:0] load_val,
    input  logic [VALUE_BITS-1:0] prev_val,
    input  logic [VALUE_BITS-1:0] next_val,
    output logic [VALUE_BITS-1:0] value
);
    import bdq_pkg::*;

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (load)
        begin
            val_next = load_val;
        end
        else
        begin
            case (ctrl.mode)
                CELL_BACK:  val_next = prev_val;
                CELL_FRONT: val_next = next_val;
                default:    val_next = val_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

### rtl/core/bounded_deque_with_rotation.sv
// Top level of the bounded deque with rotation: cell chain, control and response register.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_cell.
//
//   channel | dir | payload                          | handshake
//   req     | in  | kind, cargo, index               | valid/ready
//   rsp     | out | status, value_out, count, enabled| valid/ready
//
// One request per cycle while req.ready is high; its response appears the next cycle from a register.
// Entry i of the chain is position i from the front; pushes and shifts move all
// cells at once.
// req.ready drops only while a response waits and rsp.ready is low.
// rst_n clears count, enabled flag and response valid; cell contents are not reset.
module bounded_deque_with_rotation #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 16
) (
    input logic           clk,
    input logic           rst_n,
    bdq_req_if.sink       req,
    bdq_rsp_if.source     rsp
);
    import bdq_pkg::*;

    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int CMP_BITS   = (COUNT_BITS > 4) ? COUNT_BITS : 4;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  enabled_reg, enabled_next;
    logic                  rsp_valid_reg;
    logic [2:0]            rsp_status_reg;
    logic [VALUE_BITS-1:0] rsp_value_reg;
    logic [COUNT_BITS-1:0] rsp_count_reg;
    logic                  rsp_enabled_reg;

    logic [VALUE_BITS-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]      cell_load;
    logic [DEPTH-1:0]      back_sel, tail_sel, rd_sel;
    cell_ctrl_t            ctrl;
    logic [VALUE_BITS-1:0] load_val;
    logic [VALUE_BITS-1:0] tail_val, rd_val;
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] value;
    logic                  fire;
    logic                  full, empty, bad_index;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == COUNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign bad_index = (CMP_BITS'(req.index) >= CMP_BITS'(count_reg));

    always_comb
    begin
        tail_val = '0;
        rd_val   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_sel[i] = (count_reg == COUNT_BITS'(i));
            tail_sel[i] = (count_reg == COUNT_BITS'(i + 1));
            rd_sel[i]   = (CMP_BITS'(req.index) == CMP_BITS'(i));
            tail_val    = tail_val | (cell_val[i] & {VALUE_BITS{tail_sel[i]}});
            rd_val      = rd_val | (cell_val[i] & {VALUE_BITS{rd_sel[i]}});
        end
    end

    always_comb
    begin
        status       = STATUS_OK;
        value        = '0;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        ctrl.mode    = CELL_HOLD;
        cell_load    = '0;
        load_val     = '0;
        if (fire)
        begin
            if (req.kind == KIND_CLEAR_ENABLE)
            begin
                count_next   = '0;
                enabled_next = 1'b1;
            end
            else if (req.kind > KIND_READ)
            begin
                status = STATUS_OK;
            end
            else if (!enabled_reg)
            begin
                status = STATUS_NOT_ENABLED;
            end
            else
            begin
                case (req.kind)
                    KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status = STATUS_FULL;
                        end
                        else
                        begin
                            cell_load  = back_sel;
                            load_val   = req.cargo;
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end
                    KIND_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.mode    = CELL_BACK;
                            cell_load[0] = 1'b1;
                            load_val     = req.cargo;
                            count_next   = count_reg + COUNT_BITS'(1);
                        end
                    end
                    KIND_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            value      = cell_val[0];
                            ctrl.mode  = CELL_FRONT;
                            count_next = count_reg - COUNT_BITS'(1);
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            value      = tail_val;
                            count_next = count_reg - COUNT_BITS'(1);
                        end
                    end
                    KIND_SHIFT_RIGHT:
                    begin
                        if (!empty)
                        begin
                            value        = tail_val;
                            ctrl.mode    = CELL_BACK;
                            cell_load[0] = 1'b1;
                        end
                    end
                    KIND_ROTATE_LEFT:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            ctrl.mode = CELL_FRONT;
                            cell_load = tail_sel;
                            load_val  = cell_val[0];
                        end
                    end
                    KIND_ROTATE_RIGHT:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            ctrl.mode    = CELL_BACK;
                            cell_load[0] = 1'b1;
                            load_val     = tail_val;
                        end
                    end
                    KIND_READ:
                    begin
                        if (bad_index)
                        begin
                            status = STATUS_BAD_INDEX;
                        end
                        else
                        begin
                            value = rd_val;
                        end
                    end
                    default:
                    begin
                        status = STATUS_OK;
                    end
                endcase
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_BITS-1:0] prev_v, next_v;
        if (g == 0)
        begin : g_first
            assign prev_v = '0;
        end
        else
        begin : g_mid_p
            assign prev_v = cell_val[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign next_v = '0;
        end
        else
        begin : g_mid_n
            assign next_v = cell_val[g+1];
        end
        bdq_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .load     (cell_load[g]),
            .load_val (load_val),
            .prev_val (prev_v),
            .next_val (next_v),
            .value    (cell_val[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            enabled_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            enabled_reg <= enabled_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_status_reg  <= status;
            rsp_value_reg   <= value;
            rsp_count_reg   <= count_next;
            rsp_enabled_reg <= enabled_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.enabled   = rsp_enabled_reg;

endmodule

### rtl/core/bdq_checker.sv
// Port-level checks for the bounded deque, attached to the top level by bind.
// Depends on bdq_pkg and bounded_deque_with_rotation.
module bdq_checker #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 5
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [2:0]            rsp_status,
    input logic [VALUE_BITS-1:0] rsp_value_out,
    input logic [COUNT_BITS-1:0] rsp_count,
    input logic                  rsp_enabled
);
    import bdq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
            && $stable(rsp_status) && $stable(rsp_count))
        else $error("stalled response changed");

    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request without response");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while response stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= COUNT_BITS'(DEPTH))
        else $error("count beyond depth");

    a_not_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_NOT_ENABLED |-> !rsp_enabled
            && rsp_value_out == '0)
        else $error("not-enabled status with enabled flag or value");

endmodule

bind bounded_deque_with_rotation bdq_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS ($clog2(DEPTH + 1))
) u_bdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_value_out (rsp.value_out),
    .rsp_count     (rsp.count),
    .rsp_enabled   (rsp.enabled)
);

### tb/tb.sv
// Self-checking testbench for bounded_deque_with_rotation: directed and random requests.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and the deque RTL.
// Responses are checked against an in-bench deque predictor in request order.
module tb;
    import bdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int VALUE_BITS  = 16;
    localparam int RAND_ITEMS  = 1600;
    localparam int CALM_TAIL   = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                  drain;
        logic [3:0]            kind;
        logic [VALUE_BITS-1:0] cargo;
        logic [3:0]            index;
    } deque_op_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [VALUE_BITS-1:0] value_out;
        logic [4:0]            count;
        logic                  enabled;
    } deque_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    bdq_req_if #(.VALUE_BITS(VALUE_BITS)) req ();
    bdq_rsp_if #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(5)) rsp ();

    bounded_deque_with_rotation #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [VALUE_BITS-1:0] shadow_mem [DEPTH];
    int                    shadow_head;
    int                    shadow_fill;
    logic                  shadow_live;

    deque_op_t  pending_ops [$];
    deque_rsp_t expected_rsps [$];
    deque_op_t  cur_op;
    int         planned_rsps;
    int         errors;
    int         cycles;

    function automatic deque_rsp_t deque_apply(input deque_op_t op);
        deque_rsp_t       r;
        int               tail;
        logic [VALUE_BITS-1:0] moved;
        r.status    = STATUS_OK;
        r.value_out = '0;
        tail = (shadow_head + shadow_fill + DEPTH - 1) % DEPTH;
        if (op.kind == KIND_CLEAR_ENABLE)
        begin
            shadow_fill = 0;
            shadow_head = 0;
            shadow_live = 1'b1;
        end
        else if (op.kind > KIND_READ)
        begin
            r.status = STATUS_OK;
        end
        else if (!shadow_live)
        begin
            r.status = STATUS_NOT_ENABLED;
        end
        else
        begin
            case (op.kind)
                KIND_PUSH_BACK:
                    if (shadow_fill >= DEPTH)
                        r.status = STATUS_FULL;
                    else
                    begin
                        shadow_mem[(shadow_head + shadow_fill) % DEPTH] = op.cargo;
                        shadow_fill++;
                    end
                KIND_PUSH_FRONT:
                    if (shadow_fill >= DEPTH)
                        r.status = STATUS_FULL;
                    else
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_mem[shadow_head] = op.cargo;
                        shadow_fill++;
                    end
                KIND_POP_FRONT:
                    if (shadow_fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        r.value_out = shadow_mem[shadow_head];
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                KIND_POP_BACK:
                    if (shadow_fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        r.value_out = shadow_mem[tail];
                        shadow_fill--;
                    end
                KIND_SHIFT_RIGHT:
                    if (shadow_fill > 0)
                    begin
                        r.value_out = shadow_mem[tail];
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_mem[shadow_head] = '0;
                    end
                KIND_ROTATE_LEFT:
                    if (shadow_fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        moved = shadow_mem[shadow_head];
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_mem[(shadow_head + shadow_fill - 1) % DEPTH] = moved;
                    end
                KIND_ROTATE_RIGHT:
                    if (shadow_fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        moved = shadow_mem[tail];
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_mem[shadow_head] = moved;
                    end
                default:
                    if (op.index >= shadow_fill)
                        r.status = STATUS_BAD_INDEX;
                    else
                        r.value_out = shadow_mem[(shadow_head + op.index) % DEPTH];
            endcase
        end
        r.count   = shadow_fill[4:0];
        r.enabled = shadow_live;
        return r;
    endfunction

    task automatic log_fault(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic add_op(input logic [3:0] kind, input logic [VALUE_BITS-1:0] cargo,
                          input logic [3:0] index, input logic drain);
        deque_op_t op;
        op.drain = drain;
        op.kind  = kind;
        op.cargo = cargo;
        op.index = index;
        pending_ops.push_back(op);
        if (!drain)
            planned_rsps++;
    endtask

    // request driver
    int   gap_left;
    int   drv_cycle;
    logic drv_idle_ok;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.kind    <= '0;
            req.cargo   <= '0;
            req.index   <= '0;
            gap_left    = 0;
            drv_cycle   = 0;
            drv_idle_ok = 1'b1;
        end
        else
        begin
            drv_cycle++;
            if (drv_cycle % 128 == 0)
                drv_idle_ok = ($urandom_range(0, 3) != 0);
            if (req.valid && req.ready)
                expected_rsps.push_back(deque_apply(cur_op));
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (pending_ops.size() == 0)
                begin
                    req.valid <= 1'b0;
                end
                else if (pending_ops[0].drain)
                begin
                    if (expected_rsps.size() == 0)
                        void'(pending_ops.pop_front());
                    req.valid <= 1'b0;
                end
                else if (drv_idle_ok && pending_ops.size() > CALM_TAIL
                         && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 15) - 1;
                    req.valid <= 1'b0;
                end
                else
                begin
                    cur_op = pending_ops.pop_front();
                    req.valid <= 1'b1;
                    req.kind  <= cur_op.kind;
                    req.cargo <= cur_op.cargo;
                    req.index <= cur_op.index;
                end
            end
        end
    end

    // response monitor
    int         hold_left;
    int         rsp_seen;
    int         mon_cycle;
    logic       mon_idle_ok;
    logic       long_hold_done;
    deque_rsp_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready      <= 1'b0;
            hold_left      = 0;
            rsp_seen       = 0;
            mon_cycle      = 0;
            mon_idle_ok    = 1'b1;
            long_hold_done = 1'b0;
        end
        else
        begin
            mon_cycle++;
            if (mon_cycle % 128 == 0)
                mon_idle_ok = ($urandom_range(0, 3) != 0);
            if (rsp.valid && rsp.ready)
            begin
                rsp_seen++;
                if (expected_rsps.size() == 0)
                    log_fault($sformatf("unexpected response: status %0d value %h count %0d en %b",
                                        rsp.status, rsp.value_out, rsp.count, rsp.enabled));
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.value_out !== want.value_out
                        || rsp.count !== want.count || rsp.enabled !== want.enabled)
                        log_fault($sformatf({"response %0d mismatch: exp status %0d value %h ",
                                             "count %0d en %b, got status %0d value %h ",
                                             "count %0d en %b"},
                                            rsp_seen, want.status, want.value_out, want.count,
                                            want.enabled, rsp.status, rsp.value_out, rsp.count,
                                            rsp.enabled));
                end
            end
            // one long back-pressure stretch to fill the block and stall requests
            if (!long_hold_done && rsp_seen >= 400)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (mon_idle_ok && rsp_seen + CALM_TAIL < planned_rsps
                     && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 15) - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int               seq;
        int               len;
        int               real_items;
        logic             mid_drain_done;
        logic [3:0]       kind;
        logic [VALUE_BITS-1:0] cargo;

        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.kind  = '0;
        req.cargo = '0;
        req.index = '0;
        rsp.ready = 1'b0;
        errors       = 0;
        planned_rsps = 0;
        shadow_head  = 0;
        shadow_fill  = 0;
        shadow_live  = 1'b0;

        // before enable
        add_op(KIND_PUSH_BACK, 16'h1234, 4'd0, 1'b0);
        add_op(KIND_PUSH_FRONT, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_POP_FRONT, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_POP_BACK, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_SHIFT_RIGHT, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_ROTATE_LEFT, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_ROTATE_RIGHT, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_READ, 16'hFFFF, 4'd0, 1'b0);
        add_op(4'd15, 16'hFFFF, 4'd15, 1'b0);
        add_op(KIND_CLEAR_ENABLE, 16'h0000, 4'd0, 1'b0);
        // empty queue
        add_op(KIND_POP_FRONT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_POP_BACK, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_ROTATE_LEFT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_ROTATE_RIGHT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_SHIFT_RIGHT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_READ, 16'h0000, 4'd0, 1'b0);
        // single entry, then a few
        add_op(KIND_PUSH_BACK, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_ROTATE_LEFT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_ROTATE_RIGHT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_PUSH_BACK, 16'hFFFF, 4'd0, 1'b0);
        add_op(KIND_PUSH_FRONT, 16'h8001, 4'd0, 1'b0);
        add_op(KIND_READ, 16'h0000, 4'd2, 1'b0);
        add_op(KIND_READ, 16'h0000, 4'd3, 1'b0);
        add_op(KIND_SHIFT_RIGHT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_POP_FRONT, 16'h0000, 4'd0, 1'b0);
        add_op(KIND_POP_BACK, 16'h0000, 4'd0, 1'b0);
        add_op(4'd9, 16'h5A5A, 4'd5, 1'b0);
        add_op(KIND_CLEAR_ENABLE, 16'h0000, 4'd0, 1'b0);
        add_op(4'd0, 16'h0000, 4'd0, 1'b1);

        real_items     = 0;
        mid_drain_done = 1'b0;
        while (real_items < RAND_ITEMS)
        begin
            seq = $urandom_range(0, 9);
            len = $urandom_range(5, 20);
            if (!mid_drain_done && real_items >= RAND_ITEMS / 2)
            begin
                mid_drain_done = 1'b1;
                add_op(4'd0, 16'h0000, 4'd0, 1'b1);
            end
            for (int k = 0; k < len; k++)
            begin
                case (seq)
                    0, 1, 2:
                        if ($urandom_range(0, 9) == 0)
                            kind = KIND_READ;
                        else
                            kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                    3, 4:
                        if ($urandom_range(0, 9) == 0)
                            kind = KIND_READ;
                        else
                            kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
                    5, 6:
                        kind = 4'($urandom_range(KIND_SHIFT_RIGHT, KIND_READ));
                    7, 8:
                        kind = 4'($urandom_range(KIND_PUSH_BACK, KIND_READ));
                    default:
                        kind = 4'($urandom_range(0, 15));
                endcase
                cargo = VALUE_BITS'($urandom);
                if ($urandom_range(0, 15) == 0)
                    cargo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                add_op(kind, cargo, 4'($urandom_range(0, 15)), 1'b0);
                if (kind <= KIND_READ)
                    real_items++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || req.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_rsps.size() != 0)
            log_fault($sformatf("%0d responses never arrived", expected_rsps.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
